// File: rtl/dday_pkg.sv
// ----------------------------------------------------------------------------
// dday_pkg
// Shared types, calendar constants and small table functions for the
// date / serial day number converter.
// ----------------------------------------------------------------------------
package dday_pkg;

    // Working width of the shared step unit (covers day counts of every year
    // that the 14-bit year field can name; even, for two-bit residue steps)
    localparam int WORD_W = 24;

    localparam int unsigned DEFAULT_MAX_YEAR = 9999;

    // Operation codes
    localparam logic ACT_TO_DAY  = 1'b0;
    localparam logic ACT_TO_DATE = 1'b1;

    // Period lengths in days
    localparam logic [WORD_W-1:0] DAYS_400Y = WORD_W'(146097);
    localparam logic [WORD_W-1:0] DAYS_100Y = WORD_W'(36524);
    localparam logic [WORD_W-1:0] DAYS_4Y   = WORD_W'(1461);
    localparam logic [WORD_W-1:0] DAYS_1Y   = WORD_W'(365);

    // Input transaction
    typedef struct packed {
        logic        action;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [13:0] year;
        logic [21:0] day_number;
    } req_t;

    // Result transaction
    typedef struct packed {
        logic [21:0] serial_day;
        logic [13:0] out_year;
        logic [3:0]  out_month;
        logic [4:0]  out_day;
        logic [8:0]  day_of_year;
        logic [2:0]  weekday;
        logic [2:0]  first_weekday;
        logic        is_leap;
        logic        invalid;
    } rsp_t;

    // Operands of the shared compare-subtract-accumulate unit
    typedef struct packed {
        logic [WORD_W-1:0] rem;
        logic [WORD_W-1:0] sub;
        logic [WORD_W-1:0] acc;
        logic [WORD_W-1:0] add;
        logic              always_take;
    } step_op_t;

    typedef struct packed {
        logic              take;
        logic [WORD_W-1:0] rem_out;
        logic [WORD_W-1:0] acc_out;
    } step_res_t;

    // Days in all years before year y (y >= 1); elaboration use only
    function automatic int unsigned days_before_year(input int unsigned y);
        int unsigned p;
        p = y - 1;
        return p * 365 + p / 4 - p / 100 + p / 400;
    endfunction

    // Length of zero-based month m0
    function automatic logic [4:0] month_days(input logic [3:0] m0, input logic leap);
        logic [4:0] len;
        unique case (m0) inside
            4'd1:                   len = leap ? 5'd29 : 5'd28;
            4'd3, 4'd5, 4'd8, 4'd10: len = 5'd30;
            default:                len = 5'd31;
        endcase
        return len;
    endfunction

    // Day length of each level of the year decomposition
    function automatic logic [WORD_W-1:0] lvl_days(input logic [1:0] lvl);
        logic [WORD_W-1:0] d;
        unique case (lvl)
            2'd0:    d = DAYS_400Y;
            2'd1:    d = DAYS_100Y;
            2'd2:    d = DAYS_4Y;
            default: d = DAYS_1Y;
        endcase
        return d;
    endfunction

    // Year length of each level of the year decomposition
    function automatic logic [WORD_W-1:0] lvl_years(input logic [1:0] lvl);
        logic [WORD_W-1:0] y;
        unique case (lvl)
            2'd0:    y = WORD_W'(400);
            2'd1:    y = WORD_W'(100);
            2'd2:    y = WORD_W'(4);
            default: y = WORD_W'(1);
        endcase
        return y;
    endfunction

    // Highest quotient bit position tried at each level
    function automatic logic [2:0] lvl_top(input logic [1:0] lvl);
        logic [2:0] t;
        unique case (lvl)
            2'd0:    t = 3'd5;
            2'd1:    t = 3'd1;
            2'd2:    t = 3'd4;
            default: t = 3'd1;
        endcase
        return t;
    endfunction

    // Residue mod 7 of a value up to 27
    function automatic logic [2:0] mod7_small(input logic [4:0] v);
        logic [4:0] r;
        r = v;
        if (r >= 5'd14)
        begin
            r = r - 5'd14;
        end
        if (r >= 5'd7)
        begin
            r = r - 5'd7;
        end
        return r[2:0];
    endfunction

endpackage

// File: rtl/dday_chan_if.sv
// ----------------------------------------------------------------------------
// dday_chan_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface dday_chan_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: rtl/dday_step.sv
// ----------------------------------------------------------------------------
// dday_step
// Shared compare-subtract-accumulate unit: when the remainder covers the
// subtrahend (or the step is forced), subtract it and add the weight.
// ----------------------------------------------------------------------------
module dday_step (
    input  dday_pkg::step_op_t  op,
    output dday_pkg::step_res_t res
);
    import dday_pkg::*;

    logic ge;

    // Compare, then subtract and accumulate on a take
    assign ge          = (op.rem >= op.sub);
    assign res.take    = ge | op.always_take;
    assign res.rem_out = res.take ? (op.rem - op.sub) : op.rem;
    assign res.acc_out = res.take ? (op.acc + op.add) : op.acc;

endmodule

// File: rtl/date_day_number_converter_core.sv
// ----------------------------------------------------------------------------
// date_day_number_converter_core
// Converts a proleptic Gregorian date to a serial day number (1 Jan year 1
// is day 1) or back, with weekday, day of year and leap-year flag.
//
//   channel | dir | payload | transaction
//   --------+-----+---------+-----------------------------------------
//   req     | in  | req_t   | one conversion request (valid & ready)
//   rsp     | out | rsp_t   | one result per request (valid & ready)
//
// A request is worked in 15 steps of the shared compare-subtract unit for
// the 400/100/4/1-year periods, up to 12 month steps, up to two fix-up
// steps and 12 two-bit weekday residue steps. A request with a field out of
// range skips them; a day beyond the month end is flagged at the output.
// rst_n clears the sequencer and the result valid flag asynchronously.
// req.ready is high only while the sequencer is idle; a finished result
// waits in the output register, and a new request is taken meanwhile.
// ----------------------------------------------------------------------------
module date_day_number_converter_core #(
    parameter int unsigned MAX_YEAR = dday_pkg::DEFAULT_MAX_YEAR
) (
    input  logic               clk,
    input  logic               rst_n,
    dday_chan_if.sink          req,
    dday_chan_if.source        rsp
);
    import dday_pkg::*;

    localparam logic [31:0] MAX_YEAR_L = 32'(MAX_YEAR);
    localparam logic [31:0] LAST_DAY   = 32'(days_before_year(MAX_YEAR + 1));
    localparam int          MOD_STEPS  = WORD_W / 2;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_YEAR  = 3'd1;
    localparam logic [2:0] ST_MONTH = 3'd2;
    localparam logic [2:0] ST_SUM   = 3'd3;
    localparam logic [2:0] ST_FIRST = 3'd4;
    localparam logic [2:0] ST_MOD   = 3'd5;
    localparam logic [2:0] ST_OUT   = 3'd6;

    // Control state
    logic [2:0]  state_reg, state_next;
    logic        rsp_valid_reg, rsp_valid_next;

    // Working registers
    logic              act_reg, act_next;
    logic              inv_reg, inv_next;
    logic [3:0]        month_reg, month_next;
    logic [4:0]        day_reg, day_next;
    logic [13:0]       yr_reg, yr_next;
    logic [8:0]        yd_reg, yd_next;
    logic [3:0]        mon_reg, mon_next;
    logic [1:0]        lvl_reg, lvl_next;
    logic [2:0]        k_reg, k_next;
    logic [1:0]        b_reg, b_next;
    logic [4:0]        c_reg, c_next;
    logic [1:0]        e_reg, e_next;
    logic [WORD_W-1:0] rem_reg, rem_next;
    logic [WORD_W-1:0] acc_reg, acc_next;
    logic [WORD_W-1:0] dn_reg, dn_next;
    logic [2:0]        wa_reg, wa_next;
    logic [2:0]        wb_reg, wb_next;
    logic [3:0]        cnt_reg, cnt_next;
    rsp_t              rsp_data_reg, rsp_data_next;

    step_op_t  op;
    step_res_t res;
    logic      leap;
    logic      late_inv;
    logic      early_inv;
    logic [4:0] md;
    req_t      rq;

    assign rq = req.payload;

    // Leap year from the period digits of (year - 1)
    assign leap = (e_reg == 2'd3) && ((c_reg != 5'd24) || (b_reg == 2'd3));
    assign md   = month_days(mon_reg, leap);

    // Day beyond the month end, only for date input
    assign late_inv = (act_reg == ACT_TO_DAY) &&
                      (day_reg > month_days(month_reg - 4'd1, leap));

    // Range check of the incoming request
    always_comb
    begin
        if (rq.action == ACT_TO_DAY)
        begin
            early_inv = (rq.month == 4'd0) || (rq.month > 4'd12) ||
                        (rq.day == 5'd0) || (rq.year == 14'd0) ||
                        ({18'd0, rq.year} > MAX_YEAR_L);
        end
        else
        begin
            early_inv = (rq.day_number == 22'd0) ||
                        ({10'd0, rq.day_number} > LAST_DAY);
        end
    end

    // Operand selection for the shared unit
    always_comb
    begin
        op = '0;
        unique case (state_reg)
            ST_YEAR:
            begin
                op.rem = rem_reg;
                op.acc = acc_reg;
                op.sub = ((act_reg == ACT_TO_DATE) ? lvl_days(lvl_reg)
                                                   : lvl_years(lvl_reg)) << k_reg;
                op.add = ((act_reg == ACT_TO_DATE) ? lvl_years(lvl_reg)
                                                   : lvl_days(lvl_reg)) << k_reg;
            end
            ST_MONTH:
            begin
                op.rem = rem_reg;
                op.acc = acc_reg;
                op.sub = WORD_W'(md);
            end
            ST_SUM:
            begin
                op.acc         = acc_reg;
                op.add         = WORD_W'(yd_reg) + WORD_W'(1);
                op.always_take = 1'b1;
            end
            ST_FIRST:
            begin
                op.rem         = dn_reg;
                op.sub         = WORD_W'(day_reg) - WORD_W'(1);
                op.acc         = dn_reg;
                op.always_take = 1'b1;
            end
            default:
            begin
                op = '0;
            end
        endcase
    end

    dday_step u_step (
        .op  (op),
        .res (res)
    );

    assign req.ready = (state_reg == ST_IDLE);

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg;
        act_next       = act_reg;
        inv_next       = inv_reg;
        month_next     = month_reg;
        day_next       = day_reg;
        yr_next        = yr_reg;
        yd_next        = yd_reg;
        mon_next       = mon_reg;
        lvl_next       = lvl_reg;
        k_next         = k_reg;
        b_next         = b_reg;
        c_next         = c_reg;
        e_next         = e_reg;
        rem_next       = rem_reg;
        acc_next       = acc_reg;
        dn_next        = dn_reg;
        wa_next        = wa_reg;
        wb_next        = wb_reg;
        cnt_next       = cnt_reg;
        rsp_data_next  = rsp_data_reg;

        // Drop the result once taken
        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    act_next   = rq.action;
                    month_next = rq.month;
                    day_next   = rq.day;
                    inv_next   = early_inv;
                    yr_next    = rq.year;
                    yd_next    = 9'(rq.day) - 9'd1;
                    mon_next   = 4'd0;
                    lvl_next   = 2'd0;
                    k_next     = lvl_top(2'd0);
                    b_next     = 2'd0;
                    c_next     = 5'd0;
                    e_next     = 2'd0;
                    acc_next   = '0;
                    dn_next    = WORD_W'(rq.day_number);
                    if (rq.action == ACT_TO_DAY)
                    begin
                        rem_next = WORD_W'(rq.year) - WORD_W'(1);
                    end
                    else
                    begin
                        rem_next = WORD_W'(rq.day_number) - WORD_W'(1);
                    end
                    state_next = early_inv ? ST_OUT : ST_YEAR;
                end
            end

            ST_YEAR:
            begin
                // One quotient bit per cycle over the four period levels
                rem_next = res.rem_out;
                acc_next = res.acc_out;
                case (lvl_reg)
                    2'd1:    b_next = {b_reg[0], res.take};
                    2'd2:    c_next = {c_reg[3:0], res.take};
                    2'd3:    e_next = {e_reg[0], res.take};
                    default: b_next = b_reg;
                endcase
                if (k_reg == 3'd0)
                begin
                    if (lvl_reg == 2'd3)
                    begin
                        if (act_reg == ACT_TO_DATE)
                        begin
                            yr_next = res.acc_out[13:0] + 14'd1;
                            yd_next = res.rem_out[8:0];
                        end
                        state_next = ST_MONTH;
                    end
                    else
                    begin
                        lvl_next = lvl_reg + 2'd1;
                        k_next   = lvl_top(lvl_reg + 2'd1);
                    end
                end
                else
                begin
                    k_next = k_reg - 3'd1;
                end
            end

            ST_MONTH:
            begin
                if (act_reg == ACT_TO_DAY)
                begin
                    // Add lengths of the months before the given one
                    if (mon_reg == month_reg - 4'd1)
                    begin
                        state_next = ST_SUM;
                    end
                    else
                    begin
                        yd_next  = yd_reg + 9'(md);
                        mon_next = mon_reg + 4'd1;
                    end
                end
                else
                begin
                    // Strip whole months off the day of year
                    if ((mon_reg != 4'd11) && res.take)
                    begin
                        rem_next = res.rem_out;
                        mon_next = mon_reg + 4'd1;
                    end
                    else
                    begin
                        day_next   = rem_reg[4:0] + 5'd1;
                        state_next = ST_FIRST;
                    end
                end
            end

            ST_SUM:
            begin
                dn_next    = res.acc_out;
                state_next = ST_FIRST;
            end

            ST_FIRST:
            begin
                // Serial day of the first of the month, and a working copy
                rem_next   = res.rem_out;
                acc_next   = res.acc_out;
                wa_next    = 3'd0;
                wb_next    = 3'd0;
                cnt_next   = 4'd0;
                state_next = ST_MOD;
            end

            ST_MOD:
            begin
                // Two bits per cycle into both weekday residues
                wa_next  = mod7_small({wa_reg, acc_reg[WORD_W-1 -: 2]});
                wb_next  = mod7_small({wb_reg, rem_reg[WORD_W-1 -: 2]});
                acc_next = {acc_reg[WORD_W-3:0], 2'b00};
                rem_next = {rem_reg[WORD_W-3:0], 2'b00};
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'(MOD_STEPS - 1))
                begin
                    state_next = ST_OUT;
                end
            end

            ST_OUT:
            begin
                // Hold until the output register is free
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_data_next = '0;
                    if (inv_reg || late_inv)
                    begin
                        rsp_data_next.invalid = 1'b1;
                    end
                    else
                    begin
                        rsp_data_next.serial_day    = dn_reg[21:0];
                        rsp_data_next.out_year      = yr_reg;
                        rsp_data_next.out_month     = mon_reg + 4'd1;
                        rsp_data_next.out_day       = day_reg;
                        rsp_data_next.day_of_year   = yd_reg;
                        rsp_data_next.weekday       = wa_reg;
                        rsp_data_next.first_weekday = wb_reg;
                        rsp_data_next.is_leap       = leap;
                    end
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        act_reg      <= act_next;
        inv_reg      <= inv_next;
        month_reg    <= month_next;
        day_reg      <= day_next;
        yr_reg       <= yr_next;
        yd_reg       <= yd_next;
        mon_reg      <= mon_next;
        lvl_reg      <= lvl_next;
        k_reg        <= k_next;
        b_reg        <= b_next;
        c_reg        <= c_next;
        e_reg        <= e_next;
        rem_reg      <= rem_next;
        acc_reg      <= acc_next;
        dn_reg       <= dn_next;
        wa_reg       <= wa_next;
        wb_reg       <= wb_next;
        cnt_reg      <= cnt_next;
        rsp_data_reg <= rsp_data_next;
    end

    assign rsp.valid   = rsp_valid_reg;
    assign rsp.payload = rsp_data_reg;

    // A new result appears only from the output state
    a_result_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp.valid) |-> $past(state_reg == ST_OUT))
        else $error("result raised outside the output state");

    // Invalid results carry no date
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.payload.invalid) |->
            (rsp.payload.serial_day == 22'd0) && (rsp.payload.out_month == 4'd0) &&
            (rsp.payload.out_day == 5'd0) && (rsp.payload.is_leap == 1'b0))
        else $error("invalid result with non-zero fields");

    // Valid results are well formed
    a_valid_range: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.payload.invalid) |->
            (rsp.payload.out_month >= 4'd1) && (rsp.payload.out_month <= 4'd12) &&
            (rsp.payload.out_day >= 5'd1) && (rsp.payload.weekday < 3'd7) &&
            (rsp.payload.first_weekday < 3'd7))
        else $error("result date or weekday out of range");

    // Residue pass never runs past its step count
    a_mod_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MOD) |-> (cnt_reg < 4'(MOD_STEPS)))
        else $error("weekday residue pass overran");

endmodule

// File: tb/date_day_number_converter_core_tb.sv
// ----------------------------------------------------------------------------
// date_day_number_converter_core_tb
// Self-checking bench for the date / serial day number converter. A short
// table of directed transactions (range ends, leap-day rules, out-of-range
// fields, ignored fields) is followed by random conversions in four phases
// of sender idling and receiver back-pressure. Every result is compared,
// field by field, with its table entry or a behavioural calendar model kept in this bench.
// ----------------------------------------------------------------------------
module date_day_number_converter_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import dday_pkg::*;

    localparam int unsigned LAST_YEAR        = DEFAULT_MAX_YEAR;
    localparam int unsigned RANDOM_PER_PHASE = 335;
    localparam int unsigned DRAIN_CYCLES     = 60;
    localparam int unsigned CYCLE_LIMIT      = 1000000;

    typedef struct {
        req_t stim;
        bit   known;
        rsp_t result;
    } vector_t;

    logic clk;
    logic rst_n;

    dday_chan_if #(.payload_t(req_t)) req_if ();
    dday_chan_if #(.payload_t(rsp_t)) rsp_if ();

    date_day_number_converter_core DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    rsp_t        pending_results[$];
    vector_t     directed_vectors[$];
    int unsigned mismatches = 0;
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned cycle_count = 0;

    // ------------------------------------------------------------------------
    // Calendar arithmetic
    // ------------------------------------------------------------------------
    function automatic bit leap_of(input int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    // Length of month m (1..12)
    function automatic int unsigned month_length(input int unsigned y, input int unsigned m);
        int unsigned len;
        case (m)
            2:          len = leap_of(y) ? 29 : 28;
            4, 6, 9, 11: len = 30;
            default:    len = 31;
        endcase
        return len;
    endfunction

    // Days in years 1..y inclusive
    function automatic int unsigned days_through(input int unsigned y);
        return y * 365 + y / 4 - y / 100 + y / 400;
    endfunction

    // Expected result of one conversion request
    function automatic rsp_t convert_date(input req_t r);
        rsp_t        res;
        int unsigned y;
        int unsigned m;
        int unsigned d;
        int unsigned dn;
        int unsigned doy;
        int unsigned rest;
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        int unsigned k;
        res = '0;
        if (r.action == ACT_TO_DAY)
        begin
            y = r.year;
            m = r.month;
            d = r.day;
            if (m < 1 || m > 12 || y < 1 || y > LAST_YEAR || d < 1 || d > month_length(y, m))
            begin
                res.invalid = 1'b1;
                return res;
            end
            doy = d - 1;
            for (k = 1; k < m; k++)
            begin
                doy += month_length(y, k);
            end
            dn = days_through(y - 1) + doy + 1;
        end
        else
        begin
            dn = r.day_number;
            if (dn < 1 || dn > days_through(LAST_YEAR))
            begin
                res.invalid = 1'b1;
                return res;
            end
            // Search for the first year whose last day is not before dn
            lo = 1;
            hi = LAST_YEAR;
            while (lo < hi)
            begin
                mid = (lo + hi) / 2;
                if (days_through(mid) >= dn)
                begin
                    hi = mid;
                end
                else
                begin
                    lo = mid + 1;
                end
            end
            y = lo;
            doy = dn - days_through(y - 1) - 1;
            rest = doy;
            m = 1;
            while (rest >= month_length(y, m))
            begin
                rest -= month_length(y, m);
                m++;
            end
            d = rest + 1;
        end
        res.serial_day    = 22'(dn);
        res.out_year      = 14'(y);
        res.out_month     = 4'(m);
        res.out_day       = 5'(d);
        res.day_of_year   = 9'(doy);
        res.weekday       = 3'(dn % 7);
        res.first_weekday = 3'((dn - d + 1) % 7);
        res.is_leap       = leap_of(y);
        res.invalid       = 1'b0;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic req_t make_req(input logic act, input int unsigned m,
                                      input int unsigned d, input int unsigned y,
                                      input int unsigned dn);
        req_t r;
        r.action     = act;
        r.month      = 4'(m);
        r.day        = 5'(d);
        r.year       = 14'(y);
        r.day_number = 22'(dn);
        return r;
    endfunction

    function automatic rsp_t date_rsp(input int unsigned dn, input int unsigned y,
                                      input int unsigned m, input int unsigned d,
                                      input int unsigned doy, input int unsigned wd,
                                      input int unsigned fwd, input bit leap);
        rsp_t res;
        res.serial_day    = 22'(dn);
        res.out_year      = 14'(y);
        res.out_month     = 4'(m);
        res.out_day       = 5'(d);
        res.day_of_year   = 9'(doy);
        res.weekday       = 3'(wd);
        res.first_weekday = 3'(fwd);
        res.is_leap       = leap;
        res.invalid       = 1'b0;
        return res;
    endfunction

    // Mostly well-formed requests, with noise in the unused fields
    function automatic req_t random_request();
        req_t        r;
        logic [63:0] noise;
        int unsigned pick;
        int unsigned y;
        int unsigned m;
        noise = {$urandom, $urandom};
        r = noise[$bits(req_t)-1:0];
        pick = $urandom_range(99);
        if (r.action == ACT_TO_DAY)
        begin
            if (pick < 85)
            begin
                if (pick < 6)
                begin
                    y = ($urandom_range(1) == 0) ? 1 : LAST_YEAR;
                end
                else if (pick < 15)
                begin
                    y = 100 * $urandom_range(1, 99);
                end
                else
                begin
                    y = $urandom_range(1, LAST_YEAR);
                end
                m = $urandom_range(1, 12);
                r.year  = 14'(y);
                r.month = 4'(m);
                if ($urandom_range(3) == 0)
                begin
                    r.day = 5'(month_length(y, m));
                end
                else
                begin
                    r.day = 5'($urandom_range(1, month_length(y, m)));
                end
            end
        end
        else
        begin
            if (pick < 80)
            begin
                r.day_number = 22'($urandom_range(1, days_through(LAST_YEAR)));
            end
            else if (pick < 92)
            begin
                // Land on or next to a year end
                y = $urandom_range(1, LAST_YEAR);
                r.day_number = 22'(days_through(y) + $urandom_range(2) - 1);
            end
        end
        return r;
    endfunction

    // Offer one transaction and record its expected result on acceptance
    task automatic issue(input req_t item, input bit known, input rsp_t given);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid   <= 1'b1;
        req_if.payload <= item;
        @(posedge clk);
        while (!req_if.ready)
        begin
            @(posedge clk);
        end
        pending_results.push_back(known ? given : convert_date(item));
    endtask

    task automatic check_field(input string field, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, field, want, got);
            mismatches++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // ------------------------------------------------------------------------
    // Receiver back-pressure
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // ------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : result_check
        rsp_t want;
        rsp_t got;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            got = rsp_if.payload;
            if (pending_results.size() == 0)
            begin
                $display("%0t: result with no request outstanding, expected none, actual %p",
                         $realtime, got);
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("serial_day",    want.serial_day,    got.serial_day);
                check_field("out_year",      want.out_year,      got.out_year);
                check_field("out_month",     want.out_month,     got.out_month);
                check_field("out_day",       want.out_day,       got.out_day);
                check_field("day_of_year",   want.day_of_year,   got.day_of_year);
                check_field("weekday",       want.weekday,       got.weekday);
                check_field("first_weekday", want.first_weekday, got.first_weekday);
                check_field("is_leap",       want.is_leap,       got.is_leap);
                check_field("invalid",       want.invalid,       got.invalid);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d results still outstanding",
                     $realtime, pending_results.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        rsp_t        bad;
        rsp_t        first_day;
        rsp_t        last_day;
        int unsigned phase;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        rst_n          = 1'b0;
        req_if.valid   <= 1'b0;
        req_if.payload <= '0;

        bad = '0;
        bad.invalid = 1'b1;
        first_day = date_rsp(1, 1, 1, 1, 0, 1, 1, 1'b0);
        last_day  = date_rsp(3652059, 9999, 12, 31, 364, 5, 3, 1'b0);

        // Ends of the range, both directions
        directed_vectors.push_back('{make_req(ACT_TO_DAY, 1, 1, 1, 0), 1'b1, first_day});
        directed_vectors.push_back('{make_req(ACT_TO_DATE, 0, 0, 0, 1), 1'b1, first_day});
        directed_vectors.push_back('{make_req(ACT_TO_DATE, 0, 0, 0, 3652059), 1'b1, last_day});
        directed_vectors.push_back('{make_req(ACT_TO_DAY, 12, 31, 9999, 0), 1'b1, last_day});
        // Day number out of range
        directed_vectors.push_back('{make_req(ACT_TO_DATE, 1, 1, 1, 0), 1'b1, bad});
        directed_vectors.push_back('{make_req(ACT_TO_DATE, 1, 1, 1, 3652060), 1'b1, bad});
        directed_vectors.push_back('{make_req(ACT_TO_DATE, 1, 1, 1, 22'h3FFFFF), 1'b1, bad});
        // Month, day or year out of range
        directed_vectors.push_back('{make_req(ACT_TO_DAY, 0, 1, 2000, 0), 1'b1, bad});
        directed_vectors.push_back('{make_req(ACT_TO_DAY, 13, 1, 2000, 0), 1'b1, bad});
        directed_vectors.push_back('{make_req(ACT_TO_DAY, 15, 31, 16383, 0), 1'b1, bad});
        directed_vectors.push_back('{make_req(ACT_TO_DAY, 6, 0, 2000, 0), 1'b1, bad});
        directed_vectors.push_back('{make_req(ACT_TO_DAY, 4, 31, 2023, 0), 1'b1, bad});
        directed_vectors.push_back('{make_req(ACT_TO_DAY, 2, 29, 1900, 0), 1'b1, bad});
        directed_vectors.push_back('{make_req(ACT_TO_DAY, 2, 29, 2001, 0), 1'b1, bad});
        directed_vectors.push_back('{make_req(ACT_TO_DAY, 3, 1, 0, 0), 1'b1, bad});
        directed_vectors.push_back('{make_req(ACT_TO_DAY, 1, 1, 10000, 0), 1'b1, bad});
        // Leap days and period boundaries
        directed_vectors.push_back('{make_req(ACT_TO_DAY, 2, 29, 2000, 0), 1'b0, bad});
        directed_vectors.push_back('{make_req(ACT_TO_DAY, 2, 29, 2004, 0), 1'b0, bad});
        directed_vectors.push_back('{make_req(ACT_TO_DATE, 0, 0, 0, 146097), 1'b0, bad});
        directed_vectors.push_back('{make_req(ACT_TO_DATE, 0, 0, 0, 146098), 1'b0, bad});
        directed_vectors.push_back('{make_req(ACT_TO_DATE, 0, 0, 0, 36525), 1'b0, bad});
        directed_vectors.push_back('{make_req(ACT_TO_DAY, 12, 31, 1600, 0), 1'b0, bad});
        directed_vectors.push_back('{make_req(ACT_TO_DAY, 8, 31, 5000, 0), 1'b0, bad});
        // Unused fields set to all ones must be ignored
        directed_vectors.push_back('{make_req(ACT_TO_DATE, 15, 31, 16383, 730120), 1'b0, bad});
        directed_vectors.push_back('{make_req(ACT_TO_DAY, 7, 4, 1776, 22'h3FFFFF), 1'b0, bad});

        // Hold reset, then release it
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 69;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 69;
                end
                default:
                begin
                    send_idle_pct  = 27;
                    recv_stall_pct = 27;
                end
            endcase
            if (phase == 0)
            begin
                foreach (directed_vectors[i])
                begin
                    issue(directed_vectors[i].stim, directed_vectors[i].known,
                          directed_vectors[i].result);
                end
            end
            repeat (RANDOM_PER_PHASE)
            begin
                issue(random_request(), 1'b0, bad);
            end
        end
        req_if.valid <= 1'b0;

        // Drain outstanding results, then watch for strays
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/dday_pkg.sv
rtl/dday_chan_if.sv
rtl/dday_step.sv
rtl/date_day_number_converter_core.sv
tb/date_day_number_converter_core_tb.sv
